/* hdl/epbfa_pkg.sv */
// Shared definitions for the endpoint best-fit allocator.
// Holds item kinds, transfer types, capability bit positions and control structs.
// No dependencies.
package epbfa_pkg;

   localparam int unsigned HW_EP_SLOTS_DEF = 16;

   localparam int unsigned KIND_W = 2;
   localparam int unsigned SLOT_W = 4;
   localparam int unsigned CAPS_W = 6;
   localparam int unsigned SIZE_W = 12;
   localparam int unsigned TYPE_W = 2;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;

   // Transfer types
   localparam logic [TYPE_W-1:0] XFER_CONTROL   = 2'd0;
   localparam logic [TYPE_W-1:0] XFER_ISOCH     = 2'd1;
   localparam logic [TYPE_W-1:0] XFER_BULK      = 2'd2;
   localparam logic [TYPE_W-1:0] XFER_INTERRUPT = 2'd3;

   // Capability bit positions
   localparam int unsigned CAP_CONTROL   = 0;
   localparam int unsigned CAP_IN        = 1;
   localparam int unsigned CAP_OUT       = 2;
   localparam int unsigned CAP_INTERRUPT = 3;
   localparam int unsigned CAP_ISOCH     = 4;
   localparam int unsigned CAP_BULK      = 5;

   // Controller to datapath
   typedef struct packed {
      logic take_item;   // latch the accepted transaction, apply load or clear
      logic scan_step;   // evaluate the current slot and advance
      logic finish;      // write the result register, commit the reservation
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;   // current slot ends the scan
      logic out_free;    // result register can take a new result
   } status_type;

endpackage

/* hdl/epbfa_ctrl.sv */
// Sequencing controller for the endpoint best-fit allocator.
// Depends on epbfa_pkg for item kinds and the command and status structs.
module epbfa_ctrl
   import epbfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [KIND_W-1:0] req_kind,
   input  status_type        status,
   output cmd_type           cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.take_item = accept;
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.finish    = (state_ff == ST_DONE) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_kind == KIND_REQUEST) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_scan_ends_in_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && status.scan_done |=> (state_ff == ST_DONE))
      else $error("scan end did not move to result stage");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("ready raised while an item is in work");

   a_finish_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == ST_IDLE))
      else $error("result written but controller not idle");

endmodule

/* hdl/epbfa_dp.sv */
// Datapath for the endpoint best-fit allocator: profile table, reservation
// bitmaps, scan index, best-fit tracking and result register.
// Depends on epbfa_pkg; driven by epbfa_ctrl through cmd_type.
module epbfa_dp
   import epbfa_pkg::*;
#(
   parameter int unsigned HW_EP_SLOTS = HW_EP_SLOTS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic              req_entry_valid,
   input  logic [CAPS_W-1:0] req_capabilities,
   input  logic              req_simplex_mark,
   input  logic [SIZE_W-1:0] req_hw_frame_size,
   input  logic [TYPE_W-1:0] req_transfer_type,
   input  logic              req_direction_in,
   input  logic [SIZE_W-1:0] req_wanted_frame_size,
   input  logic              req_skip_simplex_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_matched,
   output logic [SLOT_W-1:0] rsp_hw_endpoint,
   output logic              rsp_reserve_in,
   output logic              rsp_reserve_out,
   output logic [SIZE_W-1:0] rsp_granted_frame_size
);

   localparam int unsigned IDX_W = $clog2(HW_EP_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HW_EP_SLOTS - 1);

   // Profile table: valid bits reset, payload does not
   logic [HW_EP_SLOTS-1:0] valid_ff;
   logic [CAPS_W-1:0]      caps_ff    [HW_EP_SLOTS];
   logic                   simplex_ff [HW_EP_SLOTS];
   logic [SIZE_W-1:0]      size_ff    [HW_EP_SLOTS];

   logic [HW_EP_SLOTS-1:0] in_reserved_ff, out_reserved_ff;

   // Latched request
   logic              is_request_ff;
   logic [TYPE_W-1:0] type_ff;
   logic              dir_in_ff, dir_out_ff;
   logic [SIZE_W-1:0] wanted_ff;
   logic              skip_ff;

   // Scan state
   logic [IDX_W-1:0]  idx_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  best_ff;
   logic [SIZE_W-1:0] dist_ff;
   logic [SIZE_W-1:0] best_size_ff;
   logic              best_simplex_ff;

   // Result register
   logic              rsp_valid_ff;
   logic              rsp_matched_ff;
   logic [SLOT_W-1:0] rsp_ep_ff;
   logic              rsp_res_in_ff, rsp_res_out_ff;
   logic [SIZE_W-1:0] rsp_size_ff;

   logic              load_hit;
   logic              res_skip, ent_valid, suit, type_ok, dir_ok, fits, cand, better, last;
   logic [CAPS_W-1:0] ent_caps;
   logic [SIZE_W-1:0] ent_size, d;
   logic              commit, r_in, r_out;
   logic [HW_EP_SLOTS-1:0] best_bit;

   assign load_hit = ({1'b0, req_slot} < (SLOT_W + 1)'(HW_EP_SLOTS));

   // Evaluate slot idx_ff
   always_comb begin
      ent_valid = valid_ff[idx_ff];
      ent_caps  = caps_ff[idx_ff];
      ent_size  = size_ff[idx_ff];
      res_skip  = (dir_in_ff && in_reserved_ff[idx_ff]) ||
                  (dir_out_ff && out_reserved_ff[idx_ff]);
      dir_ok    = dir_in_ff ? ent_caps[CAP_IN] : ent_caps[CAP_OUT];
      type_ok   = (ent_caps[CAP_INTERRUPT] && (type_ff == XFER_INTERRUPT)) ||
                  (ent_caps[CAP_ISOCH]     && (type_ff == XFER_ISOCH))     ||
                  (ent_caps[CAP_BULK]      && (type_ff == XFER_BULK));
      suit      = (type_ff == XFER_CONTROL) ? ent_caps[CAP_CONTROL] : (dir_ok && type_ok);
      if (ent_size >= wanted_ff) begin
         d    = ent_size - wanted_ff;
         fits = 1'b1;
      end else begin
         d    = wanted_ff - ent_size;
         fits = (type_ff == XFER_BULK) || (type_ff == XFER_CONTROL);
      end
      cand   = !res_skip && ent_valid && (simplex_ff[idx_ff] != skip_ff) && suit && fits;
      better = cand && (!found_ff || (d < dist_ff));
      last   = (idx_ff == LAST_IDX);
   end

   assign status.scan_done = (!res_skip && !ent_valid) || last;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign commit   = cmd.finish && is_request_ff && found_ff;
   assign r_in     = dir_in_ff  || best_simplex_ff;
   assign r_out    = dir_out_ff || best_simplex_ff;
   assign best_bit = HW_EP_SLOTS'(1) << best_ff;

   // Table payload: written by load items, no reset
   always_ff @(posedge clock) begin
      if (cmd.take_item && (req_kind == KIND_LOAD) && load_hit) begin
         caps_ff[req_slot[IDX_W-1:0]]    <= req_capabilities;
         simplex_ff[req_slot[IDX_W-1:0]] <= req_simplex_mark;
         size_ff[req_slot[IDX_W-1:0]]    <= req_hw_frame_size;
      end
   end

   // Valid bits and reservation bitmaps
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= '0;
         in_reserved_ff  <= '0;
         out_reserved_ff <= '0;
      end else begin
         if (cmd.take_item && (req_kind == KIND_LOAD) && load_hit) begin
            valid_ff[req_slot[IDX_W-1:0]] <= req_entry_valid;
         end
         if (cmd.take_item && (req_kind == KIND_CLEAR)) begin
            in_reserved_ff  <= '0;
            out_reserved_ff <= '0;
         end else if (commit) begin
            if (r_in) begin
               in_reserved_ff <= in_reserved_ff | best_bit;
            end
            if (r_out) begin
               out_reserved_ff <= out_reserved_ff | best_bit;
            end
         end
      end
   end

   // Latch request fields and run the scan
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         is_request_ff <= (req_kind == KIND_REQUEST);
         type_ff       <= req_transfer_type;
         dir_in_ff     <= (req_transfer_type == XFER_CONTROL) || req_direction_in;
         dir_out_ff    <= (req_transfer_type == XFER_CONTROL) || !req_direction_in;
         wanted_ff     <= req_wanted_frame_size;
         skip_ff       <= req_skip_simplex_value;
         idx_ff        <= IDX_W'(1);
         found_ff      <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (better) begin
            found_ff        <= 1'b1;
            best_ff         <= idx_ff;
            dist_ff         <= d;
            best_size_ff    <= ent_size;
            best_simplex_ff <= simplex_ff[idx_ff];
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_matched_ff <= commit;
         rsp_ep_ff      <= commit ? SLOT_W'(best_ff) : '0;
         rsp_res_in_ff  <= commit && r_in;
         rsp_res_out_ff <= commit && r_out;
         rsp_size_ff    <= !commit ? '0 :
                           ((wanted_ff > best_size_ff) ? best_size_ff : wanted_ff);
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_matched            = rsp_matched_ff;
   assign rsp_hw_endpoint        = rsp_ep_ff;
   assign rsp_reserve_in         = rsp_res_in_ff;
   assign rsp_reserve_out        = rsp_res_out_ff;
   assign rsp_granted_frame_size = rsp_size_ff;

   a_slot0_never_reserved: assert property (@(posedge clock) disable iff (reset)
      !in_reserved_ff[0] && !out_reserved_ff[0])
      else $error("slot zero reserved");

   a_scan_index_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> (idx_ff != '0))
      else $error("scan reached slot zero");

   a_match_reserves: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_matched_ff && (rsp_res_in_ff || rsp_res_out_ff) &&
                 (rsp_size_ff <= $past(wanted_ff)))
      else $error("match without reservation or with oversize grant");

   a_reservations_grow: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take_item && (req_kind == KIND_CLEAR)) |=>
         ((in_reserved_ff & $past(in_reserved_ff)) == $past(in_reserved_ff)) &&
         ((out_reserved_ff & $past(out_reserved_ff)) == $past(out_reserved_ff)))
      else $error("reservation dropped without a clear");

endmodule

/* hdl/endpoint_best_fit_allocator.sv */
// Top level of the endpoint best-fit allocator.
// Instantiates epbfa_ctrl and epbfa_dp; depends on epbfa_pkg.
//
// The block keeps up to HW_EP_SLOTS hardware endpoint profiles and an IN and
// an OUT reservation bitmap, and answers every input transaction with exactly
// one result transaction. A load transaction writes one profile slot, a clear
// transaction empties both bitmaps, and a request transaction walks slots 1
// upwards, one slot per clock through the single read port of the profile
// table, stopping at the first free slot that holds no profile. The best fit
// (smallest frame-size distance, lowest slot on a tie) is reserved and
// reported with its frame size clipped to the wanted size; a failed request
// and every non-request transaction return all-zero fields. A load or clear
// goes from acceptance straight to the result stage, a request first walks
// the slots; the result stage writes the result register only while that
// register is empty or being read through rsp_ready, and waits otherwise.
// Items are processed one at a time, and the next transaction is accepted
// once the current result has been placed in the output register, even while
// that result still waits for rsp_ready. Slot 0 can be loaded but is never
// scanned; loads beyond the last slot are dropped. Reset is synchronous and
// clears all profile valid bits and both bitmaps.
module endpoint_best_fit_allocator
   import epbfa_pkg::*;
#(
   parameter int unsigned HW_EP_SLOTS = HW_EP_SLOTS_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic              req_entry_valid,
   input  logic [CAPS_W-1:0] req_capabilities,
   input  logic              req_simplex_mark,
   input  logic [SIZE_W-1:0] req_hw_frame_size,
   input  logic [TYPE_W-1:0] req_transfer_type,
   input  logic              req_direction_in,
   input  logic [SIZE_W-1:0] req_wanted_frame_size,
   input  logic              req_skip_simplex_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_matched,
   output logic [SLOT_W-1:0] rsp_hw_endpoint,
   output logic              rsp_reserve_in,
   output logic              rsp_reserve_out,
   output logic [SIZE_W-1:0] rsp_granted_frame_size
);

   cmd_type    cmd;
   status_type status;

   // Sequencer: accept, walk the slots, hand the result over
   epbfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd)
   );

   // Profile table, bitmaps, best-fit tracking and result register
   epbfa_dp #(
      .HW_EP_SLOTS (HW_EP_SLOTS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_kind               (req_kind),
      .req_slot               (req_slot),
      .req_entry_valid        (req_entry_valid),
      .req_capabilities       (req_capabilities),
      .req_simplex_mark       (req_simplex_mark),
      .req_hw_frame_size      (req_hw_frame_size),
      .req_transfer_type      (req_transfer_type),
      .req_direction_in       (req_direction_in),
      .req_wanted_frame_size  (req_wanted_frame_size),
      .req_skip_simplex_value (req_skip_simplex_value),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_matched            (rsp_matched),
      .rsp_hw_endpoint        (rsp_hw_endpoint),
      .rsp_reserve_in         (rsp_reserve_in),
      .rsp_reserve_out        (rsp_reserve_out),
      .rsp_granted_frame_size (rsp_granted_frame_size)
   );

endmodule
